// ----- rtl/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uer_pkg;

  // Rounds averaged per measurement (1 to 7)
  localparam int Samples = 5;

  localparam int TrigW  = 10;
  localparam int TmoW   = 16;
  localparam int ScaleW = 16;
  localparam int CountW = 16;
  localparam int SumW   = 19;
  localparam int RoundW = 3;
  localparam int DistW  = 18;
  localparam int ProdW  = SumW + ScaleW;

  // Product is in 1/65536 cm; dropping 8 bits gives 1/256 cm
  localparam int FracDrop = 8;
  localparam int QuotInW  = ProdW - FracDrop;

  // floor(x / Samples) = (x * DivRecip) >> DivShift for x below 2**QuotInW
  localparam int DivShift = 34;
  localparam int RecipW   = DivShift + 1;
  localparam logic [RecipW-1:0] DivRecip =
    RecipW'(((64'd1 << DivShift) + 64'(Samples) - 64'd1) / 64'(Samples));
  localparam int MulW  = QuotInW + RecipW;
  localparam int QuotW = MulW - DivShift;

  localparam logic [DistW-1:0] DistMax = '1;

  // Register indexes on the configuration port
  localparam logic [1:0] RegTrigger = 2'd0;
  localparam logic [1:0] RegTimeout = 2'd1;
  localparam logic [1:0] RegScale   = 2'd2;

  typedef struct packed {
    logic [TrigW-1:0]  trigger_ticks;
    logic [TmoW-1:0]   timeout_ticks;
    logic [ScaleW-1:0] scale_per_tick;
  } cfg_t;

  // One tick's result from the sequencer, before scaling
  typedef struct packed {
    logic            trigger;
    logic            busy_res;
    logic            done_res;
    logic            timed_out;
    logic [SumW-1:0] tick_sum;
  } tick_res_t;

endpackage

// ----- rtl/uer_ctrl.sv -----
// Measurement sequencer: trigger, rise wait, high count and round sums.
// Depends on uer_pkg; its result register is the first pipeline stage.
`timescale 1ns / 1ps

module uer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              start_req_i,
  input  logic              echo_i,
  input  logic              adv_i,
  input  uer_pkg::cfg_t     cfg_i,
  output logic              valid_o,
  output uer_pkg::tick_res_t res_o
);
  import uer_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhTrig = 2'd1;
  localparam logic [1:0] PhRise = 2'd2;
  localparam logic [1:0] PhHigh = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [CountW-1:0] pc_q, pc_d;
  logic [CountW-1:0] hc_q, hc_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic              seen_q, seen_d;

  logic              valid_q;
  tick_res_t         res_q, res_d;

  logic [TmoW-1:0]   tmo;
  logic [CountW-1:0] pc_inc;
  logic [CountW-1:0] hc_inc;
  logic              close;
  logic [CountW-1:0] add;
  logic              done;

  assign tmo    = (cfg_i.timeout_ticks == '0) ? TmoW'(1) : cfg_i.timeout_ticks;
  assign pc_inc = pc_q + CountW'(1);
  assign hc_inc = hc_q + CountW'(1);

  always_comb begin
    phase_d = phase_q;
    pc_d    = pc_q;
    hc_d    = hc_q;
    sum_d   = sum_q;
    rnd_d   = rnd_q;
    seen_d  = seen_q;
    close   = 1'b0;
    add     = '0;
    done    = 1'b0;

    unique case (phase_q)
      PhIdle: begin
        if (start_req_i) begin
          sum_d   = '0;
          rnd_d   = '0;
          seen_d  = 1'b0;
          hc_d    = '0;
          phase_d = PhTrig;
          pc_d    = CountW'(1);
        end
      end
      PhTrig: begin
        if (pc_q >= CountW'(cfg_i.trigger_ticks)) begin
          phase_d = PhRise;
          pc_d    = '0;
        end else begin
          pc_d = pc_inc;
        end
      end
      PhRise: begin
        if (echo_i) begin
          hc_d = CountW'(1);
          pc_d = '0;
          // timeout of one tick ends the round on the rising edge itself
          if (tmo == TmoW'(1)) begin
            seen_d = 1'b1;
            close  = 1'b1;
            add    = tmo;
          end else begin
            phase_d = PhHigh;
          end
        end else begin
          pc_d = pc_inc;
          if (pc_inc >= tmo) begin
            close = 1'b1;
          end
        end
      end
      default: begin
        if (echo_i) begin
          hc_d = hc_inc;
          if (hc_inc >= tmo) begin
            seen_d = 1'b1;
            close  = 1'b1;
            add    = tmo;
          end
        end else begin
          close = 1'b1;
          add   = hc_q;
        end
      end
    endcase

    if (close) begin
      sum_d = sum_q + SumW'(add);
      rnd_d = rnd_q + RoundW'(1);
      if (rnd_d >= RoundW'(Samples)) begin
        done    = 1'b1;
        phase_d = PhIdle;
        pc_d    = '0;
      end else begin
        phase_d = PhTrig;
        pc_d    = CountW'(1);
      end
    end

    res_d.trigger   = (phase_d == PhTrig);
    res_d.busy_res  = (phase_d != PhIdle);
    res_d.done_res  = done;
    res_d.timed_out = done & seen_d;
    res_d.tick_sum  = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pc_q    <= '0;
      hc_q    <= '0;
      sum_q   <= '0;
      rnd_q   <= '0;
      seen_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pc_q    <= pc_d;
      hc_q    <= hc_d;
      sum_q   <= sum_d;
      rnd_q   <= rnd_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_i) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/uer_avg.sv -----
// Scale and average pipeline: sum times scale, then divide by the round count.
// Depends on uer_pkg; the last stage is the block's output register.
`timescale 1ns / 1ps

module uer_avg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  uer_pkg::tick_res_t          res_i,
  input  logic [uer_pkg::ScaleW-1:0]  scale_i,
  output logic                        ready_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic                        trigger_o,
  output logic                        busy_res_o,
  output logic                        done_res_o,
  output logic [uer_pkg::DistW-1:0]   distance_o,
  output logic                        timed_out_o
);
  import uer_pkg::*;

  // stage 2: product
  logic             v2_q;
  tick_res_t        r2_q;
  logic [ProdW-1:0] prod_q;
  // stage 3: output
  logic             v3_q;
  logic             trig_q, busy_q, done_q, tmo_q;
  logic [DistW-1:0] dist_q;

  logic               rdy2, rdy3;
  logic [QuotInW-1:0] quot_in;
  logic [MulW-1:0]    mul;
  logic [QuotW-1:0]   quot;
  logic [DistW-1:0]   dist_d;

  assign rdy3    = ~v3_q | ready_i;
  assign rdy2    = ~v2_q | rdy3;

  assign quot_in = prod_q[ProdW-1:FracDrop];
  assign mul     = MulW'(quot_in) * MulW'(DivRecip);
  assign quot    = mul[MulW-1:DivShift];

  always_comb begin
    if (quot > QuotW'(DistMax)) begin
      dist_d = DistMax;
    end else begin
      dist_d = quot[DistW-1:0];
    end
    if (!r2_q.done_res) begin
      dist_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      r2_q   <= res_i;
      prod_q <= ProdW'(res_i.tick_sum) * ProdW'(scale_i);
    end
    if (rdy3) begin
      trig_q <= r2_q.trigger;
      busy_q <= r2_q.busy_res;
      done_q <= r2_q.done_res;
      tmo_q  <= r2_q.timed_out;
      dist_q <= dist_d;
    end
  end

  assign ready_o     = rdy2;
  assign valid_o     = v3_q;
  assign trigger_o   = trig_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign distance_o  = dist_q;
  assign timed_out_o = tmo_q;

endmodule

// ----- rtl/ultrasonic_echo_ranger_core.sv -----
// Ultrasonic echo ranger top level: configuration registers and stream ports.
// Depends on uer_pkg, uer_ctrl and uer_avg.
//
// Usage: every item on the slave stream is one microsecond tick carrying the
// start request and the sampled echo level. Every tick yields exactly one
// result item on the master stream: trigger drive, busy, done, and on the
// done tick the averaged distance (1/256 cm, saturating) and timeout flag.
// Throughput is one item per cycle unless m_axis_tready stalls; each accepted tick
// passes the sequencer register, multiply stage and divide-by-rounds stage.
// Each stage holds its item while the next is full, so s_axis_tready drops
// only once all three stages are occupied behind a stalled m_axis_tready.
// The configuration channel is always ready; write it only while idle.
// Index 0 trigger_ticks, 1 timeout_ticks, 2 scale_per_tick; others ignored.
// Reset returns the sequencer to idle, empties the pipeline and restores
// register defaults 20, 16000 and 1114.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] start_req, [1] echo
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] trigger, [1] busy_res, [2] done_res,
                                      // [20:3] distance, [21] timed_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);
  import uer_pkg::*;

  cfg_t      cfg_q;
  logic      s_accept;
  logic      v1;
  logic      rdy2;
  tick_res_t r1;

  logic             trigger, busy_res, done_res, timed_out;
  logic [DistW-1:0] distance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks  <= TrigW'(20);
      cfg_q.timeout_ticks  <= TmoW'(16000);
      cfg_q.scale_per_tick <= ScaleW'(1114);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegTrigger: cfg_q.trigger_ticks  <= cfg_data_i[TrigW-1:0];
        RegTimeout: cfg_q.timeout_ticks  <= cfg_data_i[TmoW-1:0];
        RegScale:   cfg_q.scale_per_tick <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = ~v1 | rdy2;
  assign s_accept      = s_axis_tvalid & s_axis_tready;

  uer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (s_accept),
    .start_req_i (s_axis_tdata[0]),
    .echo_i      (s_axis_tdata[1]),
    .adv_i       (rdy2),
    .cfg_i       (cfg_q),
    .valid_o     (v1),
    .res_o       (r1)
  );

  uer_avg u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v1),
    .res_i       (r1),
    .scale_i     (cfg_q.scale_per_tick),
    .ready_o     (rdy2),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .trigger_o   (trigger),
    .busy_res_o  (busy_res),
    .done_res_o  (done_res),
    .distance_o  (distance),
    .timed_out_o (timed_out)
  );

  assign m_axis_tdata = {2'b00, timed_out, distance, done_res, busy_res, trigger};

endmodule
